// ===== rtl/core/siphash24_message_hash_macros.svh =====
// ----------------------------------------------------------------------------
// siphash24 message hash assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SIPHASH24_MESSAGE_HASH_MACROS_SVH
`define SIPHASH24_MESSAGE_HASH_MACROS_SVH

// same-cycle implication
`define SH24_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SH24_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sh24_pkg.sv =====
// ----------------------------------------------------------------------------
// sh24_pkg
// lane type, initial constants and the sipround function for siphash-2-4
// ----------------------------------------------------------------------------
package sh24_pkg;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} lanes_t;

	// zero-key initial lane values
	localparam logic [63:0] IV_A      = 64'h736f6d6570736575;
	localparam logic [63:0] IV_B      = 64'h646f72616e646f6d;
	localparam logic [63:0] IV_C      = 64'h6c7967656e657261;
	localparam logic [63:0] IV_D      = 64'h7465646279746573;
	localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

	localparam lanes_t LANES_IV = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic lanes_t sip_round(input lanes_t s);
		lanes_t t;
		t = s;
		t.a = t.a + t.b; t.b = rotl(t.b, 13); t.b = t.b ^ t.a; t.a = rotl(t.a, 32);
		t.c = t.c + t.d; t.d = rotl(t.d, 16); t.d = t.d ^ t.c;
		t.a = t.a + t.d; t.d = rotl(t.d, 21); t.d = t.d ^ t.a;
		t.c = t.c + t.b; t.b = rotl(t.b, 17); t.b = t.b ^ t.c; t.c = rotl(t.c, 32);
		return t;
	endfunction

endpackage

// ===== rtl/core/sh24_two_rounds.sv =====
// ----------------------------------------------------------------------------
// sh24_two_rounds
// two chained siprounds, purely combinational
// ----------------------------------------------------------------------------
module sh24_two_rounds (
	input  sh24_pkg::lanes_t lanes_in,
	output sh24_pkg::lanes_t lanes_out
);

	sh24_pkg::lanes_t mid;

	assign mid       = sh24_pkg::sip_round(lanes_in);
	assign lanes_out = sh24_pkg::sip_round(mid);

endmodule

// ===== rtl/core/sh24_final_pipe.sv =====
// ----------------------------------------------------------------------------
// sh24_final_pipe
// finalization pipeline: last block absorb, four rounds, digest fold
// ----------------------------------------------------------------------------
module sh24_final_pipe (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_valid,
	output logic             load_ready,
	input  sh24_pkg::lanes_t load_lanes,
	input  logic [63:0]      load_block,
	output logic             hash_valid,
	input  logic             hash_stall,
	output logic [63:0]      hash
);

	logic v_s1, v_s2, v_s3, hash_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_o;

	sh24_pkg::lanes_t lanes_s1, lanes_s2, lanes_s3;
	logic [63:0]      block_s1;
	logic [63:0]      hash_q;

	sh24_pkg::lanes_t pre_s1, rnd_s1, post_s1, rnd_s2, rnd_s3;

	assign rdy_o  = !hash_valid_q || !hash_stall;
	assign rdy_s3 = !v_s3 || rdy_o;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign load_ready = rdy_s1;

	// final block enters through lane d
	always_comb begin
		pre_s1   = lanes_s1;
		pre_s1.d = lanes_s1.d ^ block_s1;
	end

	sh24_two_rounds u_absorb (.lanes_in(pre_s1),   .lanes_out(rnd_s1));
	sh24_two_rounds u_fin_lo (.lanes_in(lanes_s2), .lanes_out(rnd_s2));
	sh24_two_rounds u_fin_hi (.lanes_in(lanes_s3), .lanes_out(rnd_s3));

	// close the absorb on lane a, then the finalization tweak on lane c
	always_comb begin
		post_s1   = rnd_s1;
		post_s1.a = rnd_s1.a ^ block_s1;
		post_s1.c = rnd_s1.c ^ sh24_pkg::FINAL_XOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			hash_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= load_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_o)  hash_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && load_valid) begin
			lanes_s1 <= load_lanes;
			block_s1 <= load_block;
		end
		if (rdy_s2 && v_s1) lanes_s2 <= post_s1;
		if (rdy_s3 && v_s2) lanes_s3 <= rnd_s2;
		if (rdy_o && v_s3)  hash_q   <= rnd_s3.a ^ rnd_s3.b ^ rnd_s3.c ^ rnd_s3.d;
	end

	assign hash_valid = hash_valid_q;
	assign hash       = hash_q;

endmodule

// ===== rtl/core/siphash24_message_hash.sv =====
// ----------------------------------------------------------------------------
// siphash24_message_hash
// streaming siphash-2-4, zero key, 64-bit digest
// ----------------------------------------------------------------------------
// Takes one little-endian 64-bit message word per cycle, back to back, on the
// msg channel while msg_stall is low; byte_count only matters on the word
// flagged last (values of 8 and above count as a full word). Every word is
// absorbed in the cycle it is accepted: the lane registers feed back through
// two siprounds, and that loop sets the one-word-per-cycle rate. The last word
// also loads a three-stage finalization pipeline (final block absorb, then two
// pairs of rounds) that feeds the hash output register, and a new message can
// start right behind it. msg_stall rises only when the finalization pipeline
// is full and the hash output is held off.
// ----------------------------------------------------------------------------
`include "siphash24_message_hash_macros.svh"

module siphash24_message_hash (
	input  logic        clk,
	input  logic        arst_n,
	// message word channel
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [63:0] data,
	input  logic [3:0]  byte_count,
	input  logic        last,
	// digest channel
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [63:0] hash
);

	// running lanes and byte length, both reset to the initial state
	sh24_pkg::lanes_t lanes_q;
	logic [7:0]       length_q;

	logic             msg_acc;
	logic             full;
	logic [7:0]       len_add;
	logic [7:0]       len_new;
	logic [63:0]      tail_mask;
	logic [63:0]      fin_block;
	logic             pipe_ready;

	sh24_pkg::lanes_t pre_abs, rnd_abs, absorbed, fin_lanes;

	assign msg_acc = msg_valid && !msg_stall;

	// a word is absorbed as a full block unless it is a short last word
	assign full    = !last || (byte_count inside {[4'd8:4'd15]});
	assign len_add = full ? 8'd8 : {5'b0, byte_count[2:0]};
	assign len_new = length_q + len_add;

	// absorb the incoming word into the current lanes
	always_comb begin
		pre_abs   = lanes_q;
		pre_abs.d = lanes_q.d ^ data;
	end

	sh24_two_rounds u_absorb (.lanes_in(pre_abs), .lanes_out(rnd_abs));

	always_comb begin
		absorbed   = rnd_abs;
		absorbed.a = rnd_abs.a ^ data;
	end

	// keep only the valid tail bytes of a short last word
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tail_mask[i*8 +: 8] = (3'(i) < byte_count[2:0]) ? 8'hff : 8'h00;
		end
	end

	// final block: tail bytes with the length byte on top; a full last
	// word leaves an empty tail
	assign fin_block = (full ? 64'd0 : (data & tail_mask)) | {len_new, 56'd0};
	assign fin_lanes = full ? absorbed : lanes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q  <= sh24_pkg::LANES_IV;
			length_q <= 8'd0;
		end else if (msg_acc) begin
			if (last) begin
				// message done, start the next from the initial state
				lanes_q  <= sh24_pkg::LANES_IV;
				length_q <= 8'd0;
			end else begin
				lanes_q  <= absorbed;
				length_q <= len_new;
			end
		end
	end

	// only a last word needs room in the finalization pipeline, but the
	// stall is kept independent of the payload
	assign msg_stall = !pipe_ready;

	sh24_final_pipe u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (msg_valid && last),
		.load_ready (pipe_ready),
		.load_lanes (fin_lanes),
		.load_block (fin_block),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash       (hash)
	);

	// state returns to the initial constants after every message
	`SH24_ASSERT_NEXT(a_len_clear, msg_acc && last, length_q == 8'd0, "length not cleared")
	`SH24_ASSERT_NEXT(a_lanes_iv, msg_acc && last, lanes_q == sh24_pkg::LANES_IV,
		"lanes not reloaded")
	// a word that is not last always adds eight bytes
	`SH24_ASSERT_NEXT(a_len_step, msg_acc && !last, length_q == 8'($past(length_q) + 8'd8),
		"length step wrong")
	// idle input leaves the running state alone
	`SH24_ASSERT_NEXT(a_state_hold, !msg_acc, $stable(lanes_q) && $stable(length_q),
		"state moved without transaction")

endmodule
